>>> rtl/core/csv_record_tokenizer_macros.svh
// assertion macros shared by the tokenizer rtl
// depends on nothing; included by modules that carry concurrent checks
`ifndef CSV_RECORD_TOKENIZER_MACROS_SVH
`define CSV_RECORD_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define CRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the next cycle
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define CRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/crt_pkg.sv
// types and constants of the csv record tokenizer
// depends on nothing; used by every module of the tokenizer
package crt_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] DELIM_RST  = 8'h2C;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    // byte class decided by the front end
    typedef enum logic [2:0] {
        CLS_END   = 3'd0,
        CLS_QUOTE = 3'd1,
        CLS_DELIM = 3'd2,
        CLS_LF    = 3'd3,
        CLS_CR    = 3'd4,
        CLS_OTHER = 3'd5
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] text;
    } t_entry;

    typedef enum logic [3:0] {
        ST_START = 4'b0001,
        ST_UNQ   = 4'b0010,
        ST_QUO   = 4'b0100,
        ST_AFTER = 4'b1000
    } t_pstate;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_QUOTE_UNQ = 2'd1,
        ERR_UNTERM    = 2'd2,
        ERR_AFTER_Q   = 2'd3
    } t_err;

endpackage

>>> rtl/core/crt_front.sv
// front end: input handshake, delimiter register and byte classification
// depends on crt_pkg
module crt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_op,
    input  logic [7:0]      i_text_byte,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_delimiter,
    input  logic            i_q_full,
    output logic            o_push,
    output crt_pkg::t_entry o_entry
);

    logic [7:0] r_delim;
    logic [7:0] n_delim;
    crt_pkg::t_cls w_cls;

    assign o_cfg_ready = 1'b1;
    assign n_delim     = (i_cfg_valid && o_cfg_ready) ? i_cfg_delimiter : r_delim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= crt_pkg::DELIM_RST;
        end else begin
            r_delim <= n_delim;
        end
    end

    // check order: end, quote, delimiter, line end
    always_comb begin
        priority if (i_op == crt_pkg::OP_END || i_text_byte == crt_pkg::CH_NUL) begin
            w_cls = crt_pkg::CLS_END;
        end else if (i_text_byte == crt_pkg::CH_QUOTE) begin
            w_cls = crt_pkg::CLS_QUOTE;
        end else if (i_text_byte == r_delim) begin
            w_cls = crt_pkg::CLS_DELIM;
        end else if (i_text_byte == crt_pkg::CH_LF) begin
            w_cls = crt_pkg::CLS_LF;
        end else if (i_text_byte == crt_pkg::CH_CR) begin
            w_cls = crt_pkg::CLS_CR;
        end else begin
            w_cls = crt_pkg::CLS_OTHER;
        end
    end

    assign o_in_stall    = i_q_full;
    assign o_push        = i_in_valid && !i_q_full;
    assign o_entry.cls   = w_cls;
    assign o_entry.text  = i_text_byte;

endmodule

>>> rtl/core/crt_fifo.sv
// short queue of classified words between front and back end
// depends on crt_pkg and the assertion macro header
`include "csv_record_tokenizer_macros.svh"

module crt_fifo #(
    parameter int unsigned DEPTH = crt_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crt_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output crt_pkg::t_entry o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    crt_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_do_push, w_do_pop;

    assign o_full       = (r_count == FullCnt);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_full;
    assign w_do_pop     = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LastIdx) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastIdx) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    `CRT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FullCnt)
    `CRT_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_do_push && !w_do_pop, o_head_valid)

endmodule

>>> rtl/core/crt_back.sv
// back end: four-state field parser, sticky end flags and output register
// depends on crt_pkg and the assertion macro header
`include "csv_record_tokenizer_macros.svh"

module crt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  crt_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_has_byte,
    output logic [7:0]      o_content_byte,
    output logic            o_field_end,
    output logic            o_row_end,
    output logic            o_input_done,
    output logic [1:0]      o_error_code
);

    crt_pkg::t_pstate r_state, n_state;
    logic r_row_open, n_row_open;
    logic r_swallow, n_swallow;
    logic r_finished, n_finished;
    logic r_failed, n_failed;
    logic r_out_valid, n_out_valid;

    logic          r_has_byte, r_field_end, r_row_end, r_done;
    logic [7:0]    r_content;
    crt_pkg::t_err r_err;

    logic          w_take, w_emit, w_handled;
    logic          w_hb, w_fe, w_re, w_dn;
    logic [7:0]    w_cb;
    crt_pkg::t_err w_ec;

    assign w_take = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_take;

    always_comb begin
        n_state    = r_state;
        n_row_open = r_row_open;
        n_swallow  = r_swallow;
        n_finished = r_finished;
        n_failed   = r_failed;
        w_emit     = 1'b0;
        w_handled  = 1'b0;
        w_hb       = 1'b0;
        w_cb       = '0;
        w_fe       = 1'b0;
        w_re       = 1'b0;
        w_dn       = 1'b0;
        w_ec       = crt_pkg::ERR_NONE;
        if (w_take && !r_finished && !r_failed) begin
            n_swallow = 1'b0;
            if (i_head.cls == crt_pkg::CLS_END) begin
                w_emit = 1'b1;
                if (!r_row_open) begin
                    n_finished = 1'b1;
                    w_dn       = 1'b1;
                end else if (r_state == crt_pkg::ST_QUO) begin
                    n_failed = 1'b1;
                    w_ec     = crt_pkg::ERR_UNTERM;
                end else begin
                    n_finished = 1'b1;
                    n_row_open = 1'b0;
                    n_state    = crt_pkg::ST_START;
                    w_fe       = 1'b1;
                    w_re       = 1'b1;
                    w_dn       = 1'b1;
                end
            end else if (r_swallow && i_head.text == crt_pkg::CH_LF) begin
                // lf right after a cr line end is dropped
                n_swallow = 1'b0;
            end else begin
                n_row_open = 1'b1;
                unique case (r_state)
                    crt_pkg::ST_QUO: begin
                        w_handled = 1'b1;
                        if (i_head.cls == crt_pkg::CLS_QUOTE) begin
                            n_state = crt_pkg::ST_AFTER;
                        end else begin
                            w_emit = 1'b1;
                            w_hb   = 1'b1;
                            w_cb   = i_head.text;
                        end
                    end
                    crt_pkg::ST_AFTER: begin
                        if (i_head.cls == crt_pkg::CLS_QUOTE) begin
                            w_handled = 1'b1;
                            n_state   = crt_pkg::ST_QUO;
                            w_emit    = 1'b1;
                            w_hb      = 1'b1;
                            w_cb      = crt_pkg::CH_QUOTE;
                        end
                    end
                    crt_pkg::ST_UNQ: begin
                        if (i_head.cls == crt_pkg::CLS_QUOTE) begin
                            w_handled = 1'b1;
                            n_failed  = 1'b1;
                            w_emit    = 1'b1;
                            w_ec      = crt_pkg::ERR_QUOTE_UNQ;
                        end
                    end
                    crt_pkg::ST_START: begin
                        if (i_head.cls == crt_pkg::CLS_QUOTE) begin
                            w_handled = 1'b1;
                            n_state   = crt_pkg::ST_QUO;
                        end
                    end
                    default: begin
                        w_handled = 1'b1;
                        n_state   = crt_pkg::ST_START;
                    end
                endcase
                if (!w_handled) begin
                    priority if (i_head.cls == crt_pkg::CLS_DELIM) begin
                        n_state = crt_pkg::ST_START;
                        w_emit  = 1'b1;
                        w_fe    = 1'b1;
                    end else if (i_head.cls == crt_pkg::CLS_LF ||
                                 i_head.cls == crt_pkg::CLS_CR) begin
                        n_state    = crt_pkg::ST_START;
                        n_row_open = 1'b0;
                        n_swallow  = (i_head.cls == crt_pkg::CLS_CR);
                        w_emit     = 1'b1;
                        w_fe       = 1'b1;
                        w_re       = 1'b1;
                    end else if (r_state == crt_pkg::ST_AFTER) begin
                        n_failed = 1'b1;
                        w_emit   = 1'b1;
                        w_ec     = crt_pkg::ERR_AFTER_Q;
                    end else begin
                        n_state = crt_pkg::ST_UNQ;
                        w_emit  = 1'b1;
                        w_hb    = 1'b1;
                        w_cb    = i_head.text;
                    end
                end
            end
        end
    end

    always_comb begin
        if (w_take && w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crt_pkg::ST_START;
            r_row_open  <= 1'b0;
            r_swallow   <= 1'b0;
            r_finished  <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_open  <= n_row_open;
            r_swallow   <= n_swallow;
            r_finished  <= n_finished;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_has_byte  <= w_hb;
            r_content   <= w_cb;
            r_field_end <= w_fe;
            r_row_end   <= w_re;
            r_done      <= w_dn;
            r_err       <= w_ec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_has_byte     = r_has_byte;
    assign o_content_byte = r_content;
    assign o_field_end    = r_field_end;
    assign o_row_end      = r_row_end;
    assign o_input_done   = r_done;
    assign o_error_code   = r_err;

    `CRT_ASSERT_NEXT(a_sticky_quiet, i_clk, i_rst_n,
        (r_finished || r_failed) && !(r_out_valid && i_out_stall), !r_out_valid)
    `CRT_ASSERT_SAME(a_err_alone, i_clk, i_rst_n, r_out_valid && r_err != crt_pkg::ERR_NONE,
        !r_has_byte && !r_field_end && !r_row_end && !r_done)
    `CRT_ASSERT_SAME(a_row_has_field, i_clk, i_rst_n, r_out_valid && r_row_end, r_field_end)
    `CRT_ASSERT_SAME(a_done_sticky, i_clk, i_rst_n, r_out_valid && r_done, r_finished)

endmodule

>>> rtl/core/csv_record_tokenizer.sv
// top level of the streaming csv record tokenizer
// depends on crt_pkg, crt_front, crt_fifo and crt_back

// csv_record_tokenizer splits a csv byte stream into fields and rows. each input
// word is either a text byte (op 0) or end of input (op 1); a zero byte also ends
// input. each word gives at most one result word: a content byte, a field end, a
// field end with row end, a done mark, or an error code (1 quote inside an unquoted
// field, 2 unterminated quote, 3 bad byte after a closing quote). a doubled quote
// inside a quoted field gives one quote byte, and an lf right after a cr line end
// is dropped. after done or an error the block drops every word until reset.
// throughput is one word per clock while the output is not stalled: the front end
// classifies a byte in the cycle it is accepted and writes it into a two-entry
// queue, and the back end takes one queued word per cycle into its output register.
// the user writes the delimiter register (reset comma) over the cfg port only while
// the block is idle; the block does not enforce it. the cfg port is always ready
module csv_record_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = crt_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_text_byte,
    // delimiter register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_delimiter,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_has_byte,
    output logic [7:0] o_content_byte,
    output logic       o_field_end,
    output logic       o_row_end,
    output logic       o_input_done,
    output logic [1:0] o_error_code
);

    // classified word from the front end into the queue
    logic            w_push;
    crt_pkg::t_entry w_push_entry;
    logic            w_q_full;
    // queue head into the back end
    logic            w_head_valid;
    crt_pkg::t_entry w_head;
    logic            w_pop;

    // front: handshake, delimiter register, byte classes in check order
    crt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_text_byte     (i_text_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_delimiter (i_cfg_delimiter),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    // queue decouples the input stall from the output stall
    crt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_push_entry),
        .o_full       (w_q_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // back: parser state, row and swallow flags, sticky end, output register
    crt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_has_byte     (o_has_byte),
        .o_content_byte (o_content_byte),
        .o_field_end    (o_field_end),
        .o_row_end      (o_row_end),
        .o_input_done   (o_input_done),
        .o_error_code   (o_error_code)
    );

endmodule

>>> sim/tb_csv_record_tokenizer.sv
`timescale 1ns / 1ps
// self-checking bench for csv_record_tokenizer: csv-shaped byte streams with random idling
// on both word channels, delimiter rewritten between phases while the block is idle
// depends on crt_pkg and csv_record_tokenizer
module tb_csv_record_tokenizer;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 220;
    localparam int MAX_REPORTS   = 200;

    typedef struct packed {
        crt_pkg::t_pstate pst;
        logic             row_open;
        logic             swallow_lf;
        logic             finished;
        logic             failed;
        logic [7:0]       delim;
    } t_tok_state;

    typedef struct packed {
        logic          has_byte;
        logic [7:0]    content;
        logic          field_end;
        logic          row_end;
        logic          done;
        crt_pkg::t_err err;
    } t_tok_word;

    typedef struct packed {
        logic       op;
        logic [7:0] text;
    } t_text_word;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_op     = crt_pkg::OP_TEXT;
    logic [7:0] in_text   = 8'h00;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_delim = crt_pkg::DELIM_RST;
    logic       out_stall = 1'b0;

    logic       o_in_stall;
    logic       o_cfg_ready;
    logic       o_out_valid;
    logic       o_has_byte;
    logic [7:0] o_content_byte;
    logic       o_field_end;
    logic       o_row_end;
    logic       o_input_done;
    logic [1:0] o_error_code;

    t_text_word pending_text [$];
    t_tok_word  owed_tokens [$];
    t_tok_state parse_model;
    t_tok_state plan_state;
    int         in_gap       = 0;
    int         out_wait     = 0;
    int         quiet_cycles = 0;
    int         n_bad        = 0;
    bit         burst        = 1'b0;

    csv_record_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (in_op),
        .i_text_byte     (in_text),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_delimiter (cfg_delim),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_has_byte      (o_has_byte),
        .o_content_byte  (o_content_byte),
        .o_field_end     (o_field_end),
        .o_row_end       (o_row_end),
        .o_input_done    (o_input_done),
        .o_error_code    (o_error_code)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_tok_state tok_reset();
        t_tok_state s;
        s.pst        = crt_pkg::ST_START;
        s.row_open   = 1'b0;
        s.swallow_lf = 1'b0;
        s.finished   = 1'b0;
        s.failed     = 1'b0;
        s.delim      = crt_pkg::DELIM_RST;
        return s;
    endfunction

    // one word through the field parser; returns 1 when it yields a result word
    function automatic bit tokenize_byte(inout t_tok_state s, input logic op,
                                         input logic [7:0] c, output t_tok_word w);
        logic was_swallow;
        w = '0;
        was_swallow = s.swallow_lf;
        if (s.finished || s.failed) return 1'b0;
        s.swallow_lf = 1'b0;

        // end of input, a zero byte counts as one before any other check
        if (op == crt_pkg::OP_END || c == crt_pkg::CH_NUL) begin
            if (!s.row_open) begin
                s.finished = 1'b1;
                w.done     = 1'b1;
                return 1'b1;
            end
            if (s.pst == crt_pkg::ST_QUO) begin
                s.failed = 1'b1;
                w.err    = crt_pkg::ERR_UNTERM;
                return 1'b1;
            end
            s.finished  = 1'b1;
            s.row_open  = 1'b0;
            s.pst       = crt_pkg::ST_START;
            w.field_end = 1'b1;
            w.row_end   = 1'b1;
            w.done      = 1'b1;
            return 1'b1;
        end

        if (was_swallow && c == crt_pkg::CH_LF) return 1'b0;
        s.row_open = 1'b1;

        case (s.pst)
            crt_pkg::ST_QUO: begin
                if (c == crt_pkg::CH_QUOTE) begin
                    s.pst = crt_pkg::ST_AFTER;
                    return 1'b0;
                end
                w.has_byte = 1'b1;
                w.content  = c;
                return 1'b1;
            end
            crt_pkg::ST_AFTER: begin
                if (c == crt_pkg::CH_QUOTE) begin
                    s.pst      = crt_pkg::ST_QUO;
                    w.has_byte = 1'b1;
                    w.content  = crt_pkg::CH_QUOTE;
                    return 1'b1;
                end
            end
            crt_pkg::ST_UNQ: begin
                if (c == crt_pkg::CH_QUOTE) begin
                    s.failed = 1'b1;
                    w.err    = crt_pkg::ERR_QUOTE_UNQ;
                    return 1'b1;
                end
            end
            default: begin
                if (c == crt_pkg::CH_QUOTE) begin
                    s.pst = crt_pkg::ST_QUO;
                    return 1'b0;
                end
            end
        endcase

        if (c == s.delim) begin
            s.pst       = crt_pkg::ST_START;
            w.field_end = 1'b1;
            return 1'b1;
        end
        if (c == crt_pkg::CH_LF || c == crt_pkg::CH_CR) begin
            s.pst        = crt_pkg::ST_START;
            s.row_open   = 1'b0;
            s.swallow_lf = (c == crt_pkg::CH_CR);
            w.field_end  = 1'b1;
            w.row_end    = 1'b1;
            return 1'b1;
        end
        if (s.pst == crt_pkg::ST_AFTER) begin
            s.failed = 1'b1;
            w.err    = crt_pkg::ERR_AFTER_Q;
            return 1'b1;
        end
        s.pst      = crt_pkg::ST_UNQ;
        w.has_byte = 1'b1;
        w.content  = c;
        return 1'b1;
    endfunction

    // idle cycles before the next word, with runs of back-to-back words
    function automatic int draw_wait();
        if ($urandom_range(0, 63) == 0) burst = ~burst;
        if (burst) return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [7:0] plain_byte(logic [7:0] delim);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == crt_pkg::CH_QUOTE || b == delim || b == crt_pkg::CH_LF ||
               b == crt_pkg::CH_CR);
        return b;
    endfunction

    // queue a word for the driver; with guard set, words that would end the parse are dropped
    function automatic int add_word(logic op, logic [7:0] c, bit guard);
        t_tok_state probe;
        t_tok_word  w;
        probe = plan_state;
        void'(tokenize_byte(probe, op, c, w));
        if (guard && (probe.finished || probe.failed)) return 0;
        plan_state = probe;
        pending_text.push_back(t_text_word'({op, c}));
        return 1;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    // rows of empty, plain and quoted fields, with a little noise
    task automatic plan_rows(int budget);
        int         made;
        int         nf;
        int         f;
        int         len;
        logic [7:0] d;
        logic [7:0] b;
        made = 0;
        d = plan_state.delim;
        while (made < budget) begin
            nf = $urandom_range(1, 5);
            for (f = 0; f < nf; f++) begin
                if (f != 0) made += add_word(crt_pkg::OP_TEXT, d, 1'b1);
                case ($urandom_range(0, 19))
                    0, 1, 2: begin
                    end
                    3: begin
                        len = $urandom_range(1, 4);
                        repeat (len) begin
                            b = 8'($urandom_range(0, 255));
                            made += add_word(($urandom_range(0, 7) == 0) ?
                                             crt_pkg::OP_END : crt_pkg::OP_TEXT, b, 1'b1);
                        end
                    end
                    4, 5, 6, 7, 8, 9, 10, 11: begin
                        len = $urandom_range(1, 6);
                        repeat (len) made += add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b1);
                    end
                    default: begin
                        made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b1);
                        len = $urandom_range(0, 6);
                        repeat (len) begin
                            case ($urandom_range(0, 7))
                                0: begin
                                    made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b1);
                                    made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b1);
                                end
                                1: begin
                                    case ($urandom_range(0, 2))
                                        0: b = crt_pkg::CH_LF;
                                        1: b = crt_pkg::CH_CR;
                                        default: b = d;
                                    endcase
                                    made += add_word(crt_pkg::OP_TEXT, b, 1'b1);
                                end
                                default: begin
                                    b = 8'($urandom_range(1, 255));
                                    if (b == crt_pkg::CH_QUOTE) b = 8'h27;
                                    made += add_word(crt_pkg::OP_TEXT, b, 1'b1);
                                end
                            endcase
                        end
                        made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b1);
                    end
                endcase
            end
            case ($urandom_range(0, 7))
                0, 1, 2, 3: made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_LF, 1'b1);
                4, 5: made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_CR, 1'b1);
                6: begin
                    made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_CR, 1'b1);
                    made += add_word(crt_pkg::OP_TEXT, crt_pkg::CH_LF, 1'b1);
                end
                default: begin
                end
            endcase
        end
    endtask

    // close the parse in one of its ways, then words that must be dropped
    task automatic plan_ending();
        logic [7:0] d;
        d = plan_state.delim;
        if (plan_state.pst == crt_pkg::ST_QUO)
            void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
        void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_LF, 1'b0));
        case ($urandom_range(0, 6))
            0: begin
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0));
            end
            1: begin
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_NUL, 1'b0));
            end
            2: void'(add_word(crt_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0));
            3: begin
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0));
            end
            4: begin
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
            end
            5: begin
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
            end
            default: begin
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, plain_byte(d), 1'b0));
                void'(add_word(crt_pkg::OP_TEXT, crt_pkg::CH_QUOTE, 1'b0));
                void'(add_word(crt_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0));
            end
        endcase
        repeat (8) void'(add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0));
    endtask

    // sender holds off until every result word is back and the pipe has settled
    task automatic wait_idle();
        while (pending_text.size() != 0 || in_valid || owed_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delim(logic [7:0] d);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_delim <= d;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        parse_model.delim = d;
        plan_state.delim  = d;
    endtask

    always @(posedge i_clk) begin : text_driver
        t_text_word nxt;
        t_tok_word  w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (tokenize_byte(parse_model, in_op, in_text, w)) owed_tokens.push_back(w);
            end
            if (!in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_text.size() != 0) begin
                    nxt = pending_text.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= nxt.op;
                    in_text  <= nxt.text;
                    in_gap   <= draw_wait();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : token_monitor
        t_tok_word got;
        t_tok_word want;
        int        w;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = t_tok_word'({o_has_byte, o_content_byte, o_field_end, o_row_end,
                               o_input_done, o_error_code});
            if (owed_tokens.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("%0t: result word expected none got %h", $time, got);
            end else begin
                want = owed_tokens.pop_front();
                check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
                check_field("content_byte", want.content, got.content);
                check_field("field_end", 8'(want.field_end), 8'(got.field_end));
                check_field("row_end", 8'(want.row_end), 8'(got.row_end));
                check_field("input_done", 8'(want.done), 8'(got.done));
                check_field("error_code", 8'(want.err), 8'(got.err));
            end
            w = draw_wait();
            out_wait  <= w;
            out_stall <= (w != 0);
        end else if (out_wait > 0) begin
            out_wait  <= out_wait - 1;
            out_stall <= (out_wait > 1);
        end
    end

    // no word moved on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
            || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] opening [22];
        logic [7:0] delims [8];
        int         k;
        opening = '{8'h61, 8'hFF, 8'h01, 8'h2C, 8'h2C, 8'h22, 8'h80, 8'h22, 8'h22, 8'h2C,
                    8'h0A, 8'h22, 8'h2C, 8'h22, 8'h22, 8'h0D, 8'h0A, 8'h0D, 8'h62, 8'h0A,
                    8'h7F, 8'h0A};
        delims = '{8'hFF, 8'h00, crt_pkg::CH_QUOTE, crt_pkg::CH_LF, crt_pkg::CH_CR, 8'h09,
                   8'h00, crt_pkg::DELIM_RST};
        delims[6] = 8'($urandom_range(0, 255));
        parse_model = tok_reset();
        plan_state  = tok_reset();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, quoted field with doubled quote and embedded breaks, cr lf swallow
        for (k = 0; k < 22; k++) void'(add_word(crt_pkg::OP_TEXT, opening[k], 1'b0));
        plan_rows(PHASE_WORDS);
        wait_idle();

        for (k = 0; k < 8; k++) begin
            write_delim(delims[k]);
            plan_rows(PHASE_WORDS);
            wait_idle();
        end

        plan_ending();
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (owed_tokens.size() != 0) begin
            n_bad += owed_tokens.size();
            $display("%0t: result words expected %0d more got none", $time, owed_tokens.size());
        end
        if (n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
